### design/urxf_pkg.sv
// shared constants for the uart receive fifo with error counters
// no dependencies; imported by the top level

package urxf_pkg;

  // fifo geometry
  localparam int unsigned FifoDepth = 1024;
  localparam int unsigned IdxW      = $clog2(FifoDepth);
  localparam int unsigned FillW     = $clog2(FifoDepth + 1);

  // error and drop counters
  localparam int unsigned CounterBits = 16;
  localparam int unsigned CountW      = 16;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned FuncW       = 3;

  // operation codes on func
  localparam logic [FuncW-1:0] FuncRx      = 3'd0;
  localparam logic [FuncW-1:0] FuncPop     = 3'd1;
  localparam logic [FuncW-1:0] FuncRdDrop  = 3'd2;
  localparam logic [FuncW-1:0] FuncRdOvr   = 3'd3;
  localparam logic [FuncW-1:0] FuncRdFrm   = 3'd4;
  localparam logic [FuncW-1:0] FuncClear   = 3'd5;

  typedef logic [CounterBits-1:0] cnt_t;
  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [FillW-1:0]       fill_t;

endpackage

### design/urxf_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module urxf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/uart_rx_fifo_with_error_counts_unit.sv
// top level of the uart receive fifo with overrun, framing and drop counters
// depends on urxf_pkg and urxf_ram (1024 x 8 byte store)
//
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+------------------------------------------
// in      | to block  | in_valid_i/in_stall_o | func, rx_byte, overrun/framing flags, ready
// out     | from block| out_valid_o/out_stall_i| read_byte, byte_valid, count_value
// cfg     | to block  | cfg_valid_i/cfg_ready_o| rx_enable
//
// one transaction in per cycle while in_stall_o is low; each result passes through
// the ram read stage and then the output register before it leaves
// pointers, fill level and counters update at accept; the byte store is the ram
// a stall on the output holds the read stage, which then stalls the input
// reset clears pointers, counters and rx_enable; the byte store is not cleared

module uart_rx_fifo_with_error_counts_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [urxf_pkg::FuncW-1:0]     func_i,
  input  logic [urxf_pkg::ByteW-1:0]     rx_byte_i,
  input  logic                           overrun_flag_i,
  input  logic                           framing_flag_i,
  input  logic                           data_ready_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [urxf_pkg::ByteW-1:0]     read_byte_o,
  output logic                           byte_valid_o,
  output logic [urxf_pkg::CountW-1:0]    count_value_o,
  // configuration channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i
);

  import urxf_pkg::*;

  // architectural state
  logic  rx_en_q;
  idx_t  wr_q, wr_d;
  idx_t  rd_q, rd_d;
  fill_t fill_q, fill_d;
  cnt_t  drop_q, drop_d;
  cnt_t  ovr_q, ovr_d;
  cnt_t  frm_q, frm_d;

  // read stage: holds the entry alongside the registered ram read data
  logic              pend_q;
  logic              pend_bv_q, pend_bv_d;
  logic [CountW-1:0] pend_cnt_q, pend_cnt_d;

  // output register
  logic              out_valid_q;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_bv_q;
  logic [CountW-1:0] out_cnt_q;

  // ram ports
  logic             ram_we, ram_re;
  logic [ByteW-1:0] ram_rdata;

  logic in_acc, out_free, pend_move;

  // the output register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pend_move  = pend_q && out_free;
  // read stage frees up when empty or moving into the output register
  assign in_stall_o = pend_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign cfg_ready_o = 1'b1;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic idx_t idx_next(input idx_t v);
    idx_next = (v == idx_t'(FifoDepth - 1)) ? '0 : v + idx_t'(1);
  endfunction

  // operation decode and state update
  // note: a read never hits the entry written in the same cycle, since equal
  // pointers mean empty (no read) or full (no write); no forwarding needed
  always_comb begin
    wr_d       = wr_q;
    rd_d       = rd_q;
    fill_d     = fill_q;
    drop_d     = drop_q;
    ovr_d      = ovr_q;
    frm_d      = frm_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    pend_bv_d  = 1'b0;
    pend_cnt_d = '0;
    if (in_acc) begin
      unique case (func_i)
        FuncRx: begin
          if (overrun_flag_i || framing_flag_i) begin
            // error byte is discarded
            if (overrun_flag_i) ovr_d = sat_inc(ovr_q);
            if (framing_flag_i) frm_d = sat_inc(frm_q);
          end else if (data_ready_i && rx_en_q) begin
            if (fill_q != fill_t'(FifoDepth)) begin
              ram_we = 1'b1;
              wr_d   = idx_next(wr_q);
              fill_d = fill_q + fill_t'(1);
            end else begin
              drop_d = sat_inc(drop_q);
            end
          end
        end
        FuncPop: begin
          if (fill_q != '0) begin
            ram_re    = 1'b1;
            pend_bv_d = 1'b1;
            rd_d      = idx_next(rd_q);
            fill_d    = fill_q - fill_t'(1);
          end
        end
        FuncRdDrop: begin
          pend_cnt_d = CountW'(drop_q);
          drop_d     = '0;
        end
        FuncRdOvr: begin
          pend_cnt_d = CountW'(ovr_q);
          ovr_d      = '0;
        end
        FuncRdFrm: begin
          pend_cnt_d = CountW'(frm_q);
          frm_d      = '0;
        end
        FuncClear: begin
          wr_d   = '0;
          rd_d   = '0;
          fill_d = '0;
          drop_d = '0;
          ovr_d  = '0;
          frm_d  = '0;
        end
        default: begin
          // unused codes: all-zero result, no state change
        end
      endcase
    end
  end

  urxf_ram #(
    .Width (ByteW),
    .Depth (FifoDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (rx_byte_i),
    .re_i    (ram_re),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  // control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_en_q     <= 1'b0;
      wr_q        <= '0;
      rd_q        <= '0;
      fill_q      <= '0;
      drop_q      <= '0;
      ovr_q       <= '0;
      frm_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        rx_en_q <= cfg_data_i;
      end
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
      drop_q <= drop_d;
      ovr_q  <= ovr_d;
      frm_q  <= frm_d;
      // read stage holds while the output is stalled
      if (in_acc) begin
        pend_q <= 1'b1;
      end else if (pend_move) begin
        pend_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_bv_q  <= pend_bv_d;
      pend_cnt_q <= pend_cnt_d;
    end
    if (pend_move) begin
      // ram data is held since no new read is issued while the stage is full and stalled
      out_byte_q <= pend_bv_q ? ram_rdata : '0;
      out_bv_q   <= pend_bv_q;
      out_cnt_q  <= pend_cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_byte_o   = out_byte_q;
  assign byte_valid_o  = out_bv_q;
  assign count_value_o = out_cnt_q;

  // fill level never passes the fifo depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= fill_t'(FifoDepth))
    else $error("fill level above fifo depth");

  // empty or full fifo means the pointers meet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || fill_q == fill_t'(FifoDepth)) |-> (wr_q == rd_q))
    else $error("pointers disagree with fill level");

  // an accepted clear empties the fifo and zeroes the counters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_i == FuncClear) |=>
      (fill_q == '0 && drop_q == '0 && ovr_q == '0 && frm_q == '0))
    else $error("clear left state behind");

  // a pop on a non-empty fifo yields a valid byte in the read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && func_i == FuncPop && fill_q != '0) |=> (pend_q && pend_bv_q))
    else $error("pop lost its byte");

  // the read stage never overwrites a result that has not moved on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !out_free) |-> !in_acc)
    else $error("read stage overrun");

endmodule
